// ===== src/organized_cloud_outlier_filter_defines.svh =====
// Assertion macros shared by the outlier filter RTL.
`ifndef ORGANIZED_CLOUD_OUTLIER_FILTER_DEFINES_SVH
`define ORGANIZED_CLOUD_OUTLIER_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define OCOF_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ocof assertion failed");
`define OCOF_ASSERT_NEXT(name, trig, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("ocof assertion failed");
`else
`define OCOF_ASSERT_NEVER(name, cond)
`define OCOF_ASSERT_NEXT(name, trig, cons)
`endif
`endif

// ===== src/ocof_pkg.sv =====
// Types and constants of the organized cloud outlier filter.
package ocof_pkg;

	typedef struct packed {
		logic               missing;
		logic [7:0]         score;
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} cell_t;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_DIVQ     = 11'b000_0000_0010,
		ST_CTR_RD   = 11'b000_0000_0100,
		ST_CTR_WAIT = 11'b000_0000_1000,
		ST_NB_ADDR  = 11'b000_0001_0000,
		ST_NB_WAIT  = 11'b000_0010_0000,
		ST_NB_SQ    = 11'b000_0100_0000,
		ST_NB_CHK   = 11'b000_1000_0000,
		ST_FIN      = 11'b001_0000_0000,
		ST_DIVM     = 11'b010_0000_0000,
		ST_OUT      = 11'b100_0000_0000
	} state_t;

	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_MAX_DIST  = 3'd1;
	localparam logic [2:0] REG_INTERP    = 3'd2;
	localparam logic [2:0] REG_WIDTH     = 3'd3;
	localparam logic [2:0] REG_HEIGHT    = 3'd4;

	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic [2:0] NB_LAST = 3'd7;

	// Column offset of neighbor k, going round the center.
	function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
		logic signed [1:0] v;
		unique case (k)
			3'd0, 3'd1, 3'd2: v = -2'sd1;
			3'd3, 3'd7:       v = 2'sd0;
			default:          v = 2'sd1;
		endcase
		return v;
	endfunction

	// Row offset of neighbor k.
	function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
		logic signed [1:0] v;
		unique case (k)
			3'd0, 3'd6, 3'd7: v = -2'sd1;
			3'd1, 3'd5:       v = 2'sd0;
			default:          v = 2'sd1;
		endcase
		return v;
	endfunction

endpackage

// ===== src/organized_cloud_outlier_filter.sv =====
// Top level of the organized cloud outlier filter: 3x3 outlier replacement.
//
// Points of an organized cloud enter in raster order on the s_ channel; s_tuser
// selects a new point (0) or a flush (1). Results leave on the m_ channel, one
// word per point, lagging the input by one row plus one pixel; once a frame is
// complete, each flush word drains one pending result. A point after a
// complete frame starts the next frame.
// Every point is written to a ring of 2*MAX_WIDTH+4 entries in one memory.
// A word that yields a result runs a sequencer: the row and column division,
// the center read, per neighbor at most an address step, a read, four square
// and sum steps and a compare, then a finishing step and, in interpolate mode,
// the three divisions for the means. All divisions share one iterative divider
// of DW bits (21 by default), and the memory has a single read port. The result
// then waits in an output register until m_tready is high; no new word is
// taken meanwhile.
// Configuration writes on the cfg_ channel are always accepted; input is held
// off in the cycle after a write. Reset restores the register defaults and an
// empty frame; the ring memory is not cleared.
module organized_cloud_outlier_filter
	import ocof_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x[15:0], y[31:16], z[47:32], score[55:48], missing[56], zero fill
	input  logic [63:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_x[15:0], out_y[31:16], out_z[47:32]
	output logic [47:0] m_tdata,
	// out_invalid[0], out_replaced[1]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

`include "organized_cloud_outlier_filter_defines.svh"

	localparam int RING  = 2 * MAX_WIDTH + 4;
	localparam int AW    = $clog2(RING);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int DW    = (CNT_W > 20) ? CNT_W : 20;
	localparam logic signed [AW+1:0] RING_S = (AW + 2)'(RING);

	// Configuration registers.
	logic [7:0]  thr_q;
	logic [13:0] maxd_q;
	logic        interp_q;
	logic [10:0] fw_q;
	logic [10:0] fh_q;
	logic        cfg_ok_q;
	logic        cfg_acc;

	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [WW+HW-1:0] area;
	logic [CNT_W-1:0] total_q;
	logic [27:0]      lim_q;

	// Frame bookkeeping.
	state_t           st_q;
	logic [CNT_W-1:0] recv_q;
	logic [CNT_W-1:0] pend_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] q_q;
	logic [CNT_W-1:0] r_q;
	logic [WW-1:0]    c_q;
	logic [AW-1:0]    qa_q;

	logic             in_acc;
	logic             fresh;
	logic [CNT_W-1:0] recv_base;
	logic [CNT_W-1:0] pend_base;
	logic [CNT_W-1:0] recv_n;
	logic [CNT_W-1:0] pend_n;
	logic             emit_pt;
	logic             emit_fl;
	logic [AW-1:0]    wr_addr;
	logic signed [AW+1:0] qa_diff;
	logic [AW-1:0]    qa_new;

	// Memory.
	cell_t         mem [RING];
	cell_t         rd_q;
	cell_t         wr_cell;
	logic          mem_we;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// Neighbor walk.
	cell_t              ctr_q;
	logic [2:0]         k_q;
	logic signed [1:0]  dxk;
	logic signed [1:0]  dyk;
	logic               col_ok;
	logic               row_ok;
	logic               nb_take;
	logic [CNT_W:0]     r_ext;
	logic [CNT_W:0]     h_ext;
	logic [WW:0]        c_ext;
	logic [WW:0]        w_ext;
	logic signed [AW+1:0] wsg;
	logic signed [AW+1:0] asum;
	logic signed [AW+1:0] afix;
	logic [AW-1:0]      nb_addr;
	logic signed [16:0] dif_q [3];
	logic [1:0]         sq_cnt_q;
	logic signed [16:0] sel_d;
	logic signed [33:0] prod;
	logic [33:0]        sq_q;
	logic [35:0]        dist_q;
	logic signed [19:0] sx_q;
	logic signed [19:0] sy_q;
	logic signed [19:0] sz_q;
	logic [3:0]         n_q;
	logic               repl;

	// Means.
	logic [1:0]         m_q;
	logic [1:0]         mi;
	logic signed [19:0] s_sel;
	logic signed [19:0] mag;
	logic [20:0]        mdd;
	logic signed [19:0] s_done;
	logic [15:0]        mres;

	// Divider.
	logic          div_start_q;
	logic [DW-1:0] div_a_q;
	logic [DW-1:0] div_b_q;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	// Result.
	logic signed [15:0] ox_q;
	logic signed [15:0] oy_q;
	logic signed [15:0] oz_q;
	logic               inv_q;
	logic               repl_q;
	logic               fd_q;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (st_q == ST_IDLE) && cfg_ok_q;
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 8'd255;
			maxd_q   <= 14'd250;
			interp_q <= 1'b0;
			fw_q     <= 11'd640;
			fh_q     <= 11'd480;
			cfg_ok_q <= 1'b0;
		end else begin
			cfg_ok_q <= !cfg_acc;
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_THRESHOLD: thr_q    <= cfg_data[7:0];
					REG_MAX_DIST:  maxd_q   <= cfg_data[13:0];
					REG_INTERP:    interp_q <= cfg_data[0];
					REG_WIDTH:     fw_q     <= cfg_data[10:0];
					REG_HEIGHT:    fh_q     <= cfg_data[10:0];
					default: ;
				endcase
			end
		end
	end

	// Zero geometry counts as one, larger than the maximum saturates.
	always_comb begin
		int unsigned fw32;
		int unsigned fh32;
		fw32 = 32'(fw_q);
		fh32 = 32'(fh_q);
		if (fw32 == 0)
			w_eff = WW'(1);
		else if (fw32 > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(fw32);
		if (fh32 == 0)
			h_eff = HW'(1);
		else if (fh32 > MAX_HEIGHT)
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(fh32);
		area = (WW + HW)'(w_eff) * (WW + HW)'(h_eff);
	end

	always_ff @(posedge clk) begin
		total_q <= CNT_W'(area);
		lim_q   <= 28'(maxd_q) * 28'(maxd_q);
	end

	always_comb begin
		fresh     = recv_q >= total_q;
		recv_base = fresh ? '0 : recv_q;
		pend_base = fresh ? '0 : pend_q;
		recv_n    = recv_base + 1'b1;
		pend_n    = pend_base + 1'b1;
		emit_pt   = (CNT_W + 1)'(pend_n) >= (CNT_W + 1)'(w_eff) + (CNT_W + 1)'(2);
		emit_fl   = fresh && (pend_q != '0);
		wr_addr   = fresh ? '0 : wp_q;
		mem_we    = in_acc && (s_tuser == ACT_POINT);
		wr_cell   = cell_t'(s_tdata[56:0]);
		// The pending count never exceeds MAX_WIDTH+1, so the ring slot of the
		// emitted point lies less than one ring length behind the write slot.
		if (s_tuser == ACT_POINT)
			qa_diff = $signed({2'b00, wr_addr}) + $signed((AW + 2)'(1))
				- $signed((AW + 2)'(pend_n));
		else
			qa_diff = $signed({2'b00, wp_q}) - $signed((AW + 2)'(pend_q));
		if (qa_diff < 0)
			qa_new = AW'(qa_diff + RING_S);
		else
			qa_new = qa_diff[AW-1:0];
	end

	// Neighbor bounds and ring address.
	always_comb begin
		dxk   = nb_dx(k_q);
		dyk   = nb_dy(k_q);
		r_ext = {1'b0, r_q};
		h_ext = (CNT_W + 1)'(h_eff);
		c_ext = {1'b0, c_q};
		w_ext = {1'b0, w_eff};
		if (dxk < 0)
			col_ok = c_q != '0;
		else if (dxk > 0)
			col_ok = (c_ext + 1'b1) < w_ext;
		else
			col_ok = 1'b1;
		if (dyk < 0)
			row_ok = (r_q != '0) && ((r_ext - 1'b1) < h_ext);
		else if (dyk > 0)
			row_ok = (r_ext + 1'b1) < h_ext;
		else
			row_ok = r_ext < h_ext;
		nb_take = col_ok && row_ok && !ctr_q.missing;
		wsg = $signed({2'b00, AW'(w_eff)});
		asum = $signed({2'b00, qa_q}) + (AW + 2)'(dxk);
		if (dyk < 0)
			asum = asum - wsg;
		else if (dyk > 0)
			asum = asum + wsg;
		if (asum < 0)
			afix = asum + RING_S;
		else if (asum >= RING_S)
			afix = asum - RING_S;
		else
			afix = asum;
		nb_addr = afix[AW-1:0];
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = qa_q;
		if (st_q == ST_CTR_RD)
			rd_en = 1'b1;
		if ((st_q == ST_NB_ADDR) && nb_take) begin
			rd_en   = 1'b1;
			rd_addr = nb_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_cell;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_comb begin
		unique case (sq_cnt_q)
			2'd0:    sel_d = dif_q[0];
			2'd1:    sel_d = dif_q[1];
			default: sel_d = dif_q[2];
		endcase
		prod = sel_d * sel_d;
		repl = ctr_q.score > thr_q;
	end

	// Operands of the rounded means: (2|s| + n) / (2n), sign restored after.
	always_comb begin
		mi = (st_q == ST_FIN) ? 2'd0 : m_q + 2'd1;
		unique case (mi)
			2'd0:    s_sel = sx_q;
			2'd1:    s_sel = sy_q;
			default: s_sel = sz_q;
		endcase
		mag = (s_sel < 0) ? -s_sel : s_sel;
		mdd = {mag[19:0], 1'b0} + 21'(n_q);
		unique case (m_q)
			2'd0:    s_done = sx_q;
			2'd1:    s_done = sy_q;
			default: s_done = sz_q;
		endcase
		mres = (s_done < 0) ? -div_quo[15:0] : div_quo[15:0];
	end

	ocof_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			recv_q      <= '0;
			pend_q      <= '0;
			wp_q        <= '0;
			div_start_q <= 1'b0;
			k_q         <= '0;
			sq_cnt_q    <= '0;
			m_q         <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == ACT_POINT) begin
							recv_q <= recv_n;
							wp_q   <= (32'(wr_addr) == RING - 1) ? '0 : wr_addr + 1'b1;
							if (emit_pt) begin
								pend_q      <= pend_n - 1'b1;
								div_start_q <= 1'b1;
								st_q        <= ST_DIVQ;
							end else begin
								pend_q <= pend_n;
							end
						end else if (emit_fl) begin
							pend_q      <= pend_q - 1'b1;
							div_start_q <= 1'b1;
							st_q        <= ST_DIVQ;
						end
					end
				end
				ST_DIVQ: begin
					if (div_done)
						st_q <= ST_CTR_RD;
				end
				ST_CTR_RD: st_q <= ST_CTR_WAIT;
				ST_CTR_WAIT: begin
					k_q  <= '0;
					st_q <= (rd_q.score > thr_q && interp_q) ? ST_NB_ADDR : ST_FIN;
				end
				ST_NB_ADDR: begin
					if (nb_take) begin
						st_q <= ST_NB_WAIT;
					end else if (k_q == NB_LAST) begin
						st_q <= ST_FIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_NB_WAIT: begin
					sq_cnt_q <= '0;
					if (rd_q.missing || rd_q.score > thr_q) begin
						if (k_q == NB_LAST) begin
							st_q <= ST_FIN;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_NB_ADDR;
						end
					end else begin
						st_q <= ST_NB_SQ;
					end
				end
				ST_NB_SQ: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3)
						st_q <= ST_NB_CHK;
				end
				ST_NB_CHK: begin
					if (k_q == NB_LAST) begin
						st_q <= ST_FIN;
					end else begin
						k_q  <= k_q + 1'b1;
						st_q <= ST_NB_ADDR;
					end
				end
				ST_FIN: begin
					m_q <= '0;
					if (repl && interp_q && n_q != '0) begin
						div_start_q <= 1'b1;
						st_q        <= ST_DIVM;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_DIVM: begin
					if (div_done) begin
						if (m_q == 2'd2) begin
							st_q <= ST_OUT;
						end else begin
							m_q         <= m_q + 2'd1;
							div_start_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (m_tready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				q_q     <= (s_tuser == ACT_POINT) ? recv_n - pend_n : recv_q - pend_q;
				qa_q    <= qa_new;
				div_a_q <= DW'((s_tuser == ACT_POINT) ? recv_n - pend_n : recv_q - pend_q);
				div_b_q <= DW'(w_eff);
			end
			ST_DIVQ: begin
				if (div_done) begin
					r_q <= div_quo[CNT_W-1:0];
					c_q <= div_rem[WW-1:0];
				end
			end
			ST_CTR_WAIT: begin
				ctr_q <= rd_q;
				sx_q  <= '0;
				sy_q  <= '0;
				sz_q  <= '0;
				n_q   <= '0;
			end
			ST_NB_WAIT: begin
				dif_q[0] <= $signed({rd_q.x[15], rd_q.x}) - $signed({ctr_q.x[15], ctr_q.x});
				dif_q[1] <= $signed({rd_q.y[15], rd_q.y}) - $signed({ctr_q.y[15], ctr_q.y});
				dif_q[2] <= $signed({rd_q.z[15], rd_q.z}) - $signed({ctr_q.z[15], ctr_q.z});
				dist_q   <= '0;
			end
			ST_NB_SQ: begin
				// The product of one step is added in the next.
				if (sq_cnt_q != 2'd0)
					dist_q <= dist_q + {2'b00, sq_q};
				sq_q <= $unsigned(prod);
			end
			ST_NB_CHK: begin
				if (dist_q <= {8'd0, lim_q}) begin
					sx_q <= sx_q + 20'(rd_q.x);
					sy_q <= sy_q + 20'(rd_q.y);
					sz_q <= sz_q + 20'(rd_q.z);
					n_q  <= n_q + 1'b1;
				end
			end
			ST_FIN: begin
				fd_q    <= ((CNT_W + 1)'(q_q) + 1'b1) == (CNT_W + 1)'(total_q);
				repl_q  <= repl;
				div_a_q <= DW'(mdd);
				div_b_q <= DW'({n_q, 1'b0});
				ox_q    <= '0;
				oy_q    <= '0;
				oz_q    <= '0;
				inv_q   <= 1'b0;
				if (repl) begin
					inv_q <= interp_q && (n_q == '0);
				end else if (ctr_q.missing) begin
					inv_q <= 1'b1;
				end else begin
					ox_q <= ctr_q.x;
					oy_q <= ctr_q.y;
					oz_q <= ctr_q.z;
				end
			end
			ST_DIVM: begin
				if (div_done) begin
					unique case (m_q)
						2'd0:    ox_q <= $signed(mres);
						2'd1:    oy_q <= $signed(mres);
						default: oz_q <= $signed(mres);
					endcase
					div_a_q <= DW'(mdd);
					div_b_q <= DW'({n_q, 1'b0});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = st_q == ST_OUT;
	assign m_tdata  = {oz_q, oy_q, ox_q};
	assign m_tuser  = {repl_q, inv_q};
	assign m_tlast  = fd_q;

	`OCOF_ASSERT_NEVER(a_busy_while_result, s_tready && m_tvalid)
	`OCOF_ASSERT_NEVER(a_pending_le_received, pend_q > recv_q)
	`OCOF_ASSERT_NEVER(a_write_ptr_range, 32'(wp_q) >= RING)
	`OCOF_ASSERT_NEXT(a_one_result_per_word, m_tvalid && m_tready, !m_tvalid)

endmodule

// ===== src/ocof_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ocof_div #(
	parameter int DW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [DW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] nrem;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
		nrem  = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= nrem;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
